// File: hdl/pidpc_pkg.sv
package pidpc_pkg;

  localparam int POS_W  = 24;
  localparam int GAIN_W = 24;
  localparam int DRV_W  = 16;
  localparam int CNT_W  = 16;
  localparam int ACC_W  = 32;
  localparam int DER_W  = POS_W + 1;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int P_PROD_W = GAIN_W + 1 + POS_W;
  localparam int I_PROD_W = GAIN_W + 1 + ACC_W;
  localparam int D_PROD_W = GAIN_W + 1 + DER_W;
  localparam int SUM_W    = 60;
  localparam int FRAC_SH  = 16;
  localparam int SHR_W    = SUM_W - FRAC_SH;

  // register indexes, byte address = 4 * index
  localparam logic [2:0] REG_GAIN_P      = 3'd0;
  localparam logic [2:0] REG_GAIN_I      = 3'd1;
  localparam logic [2:0] REG_GAIN_D      = 3'd2;
  localparam logic [2:0] REG_MAX_POWER   = 3'd3;
  localparam logic [2:0] REG_INT_ZONE    = 3'd4;
  localparam logic [2:0] REG_INT_LIMIT   = 3'd5;
  localparam logic [2:0] REG_EXIT_THRESH = 3'd6;
  localparam logic [2:0] REG_TIMEOUT     = 3'd7;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [14:0]       max_power;
    logic [22:0]       integral_zone;
    logic [30:0]       integral_limit;
    logic [22:0]       exit_threshold;
    logic [CNT_W-1:0]  timeout_samples;
  } pidpc_cfg_t;

  localparam pidpc_cfg_t CFG_RESET = '{
    gain_p:          24'd19864,
    gain_i:          24'd524,
    gain_d:          24'd34886,
    max_power:       15'd25600,
    integral_zone:   23'd3840,
    integral_limit:  31'd1280000,
    exit_threshold:  23'd128,
    timeout_samples: 16'd65535
  };

  // error stage result handed to the product stage
  typedef struct packed {
    logic signed [POS_W-1:0] err;
    logic signed [ACC_W-1:0] acc;
    logic signed [DER_W-1:0] der;
    logic                    done;
    logic                    timed_out;
  } pidpc_err_t;

endpackage

// File: hdl/pidpc_if.sv
interface pidpc_in_if import pidpc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    first;
  logic signed [POS_W-1:0] setpoint;
  logic signed [POS_W-1:0] measured;

  modport source (output valid, output first, output setpoint, output measured, input ready);
  modport sink (input valid, input first, input setpoint, input measured, output ready);
endinterface

interface pidpc_out_if import pidpc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] drive;
  logic signed [POS_W-1:0] error_out;
  logic                    done_res;
  logic                    timed_out;

  modport source (output valid, output drive, output error_out, output done_res,
                  output timed_out, input ready);
  modport sink (input valid, input drive, input error_out, input done_res,
                input timed_out, output ready);
endinterface

// File: hdl/pidpc_regs.sv
module pidpc_regs import pidpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output pidpc_cfg_t        cfg
);

  pidpc_cfg_t  cfg_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:      cfg_r.gain_p          <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:      cfg_r.gain_i          <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg_r.gain_d          <= pwdata[GAIN_W-1:0];
        REG_MAX_POWER:   cfg_r.max_power       <= pwdata[14:0];
        REG_INT_ZONE:    cfg_r.integral_zone   <= pwdata[22:0];
        REG_INT_LIMIT:   cfg_r.integral_limit  <= pwdata[30:0];
        REG_EXIT_THRESH: cfg_r.exit_threshold  <= pwdata[22:0];
        REG_TIMEOUT:     cfg_r.timeout_samples <= pwdata[CNT_W-1:0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:      prdata = DATA_W'(cfg_r.gain_p);
      REG_GAIN_I:      prdata = DATA_W'(cfg_r.gain_i);
      REG_GAIN_D:      prdata = DATA_W'(cfg_r.gain_d);
      REG_MAX_POWER:   prdata = DATA_W'(cfg_r.max_power);
      REG_INT_ZONE:    prdata = DATA_W'(cfg_r.integral_zone);
      REG_INT_LIMIT:   prdata = DATA_W'(cfg_r.integral_limit);
      REG_EXIT_THRESH: prdata = DATA_W'(cfg_r.exit_threshold);
      REG_TIMEOUT:     prdata = DATA_W'(cfg_r.timeout_samples);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: hdl/pidpc_state.sv
module pidpc_state import pidpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic                    in_first,
  input  logic signed [POS_W-1:0] in_setpoint,
  input  logic signed [POS_W-1:0] in_measured,
  input  pidpc_cfg_t              cfg,
  output logic                    st_valid,
  output pidpc_err_t              st
);

  // input register
  logic                    s0_valid_r;
  logic                    s0_first_r;
  logic signed [POS_W-1:0] s0_sp_r;
  logic signed [POS_W-1:0] s0_ms_r;

  // loop state
  logic signed [ACC_W-1:0] integ_r;
  logic signed [POS_W-1:0] prev_r;
  logic [CNT_W-1:0]        count_r;

  logic                    st_valid_r;
  pidpc_err_t              st_r;

  logic signed [ACC_W-1:0] integ_base;
  logic signed [POS_W-1:0] prev_base;
  logic [CNT_W-1:0]        count_base;
  logic signed [POS_W:0]   diff;
  logic signed [POS_W-1:0] err;
  logic [POS_W-1:0]        mag;
  logic                    zone_hit;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W:0]   acc_raw;
  logic signed [ACC_W:0]   lim;
  logic signed [ACC_W:0]   acc_clamp;
  logic [CNT_W-1:0]        count_nxt;
  logic                    thresh_hit;
  logic                    timeout;
  pidpc_err_t              st_nxt;

  always_comb begin
    // a new move starts from cleared state
    integ_base = s0_first_r ? '0 : integ_r;
    prev_base  = s0_first_r ? '0 : prev_r;
    count_base = s0_first_r ? '0 : count_r;

    diff = {s0_sp_r[POS_W-1], s0_sp_r} - {s0_ms_r[POS_W-1], s0_ms_r};
    // saturate symmetrically: the most negative code is never produced
    priority if (diff > $signed({2'b00, {(POS_W-1){1'b1}}})) begin
      err = {1'b0, {(POS_W-1){1'b1}}};
    end else if (diff < $signed({2'b11, {(POS_W-2){1'b0}}, 1'b1})) begin
      err = {1'b1, {(POS_W-2){1'b0}}, 1'b1};
    end else begin
      err = diff[POS_W-1:0];
    end
    mag = err[POS_W-1] ? (~err + POS_W'(1)) : err;

    zone_hit = (mag < {1'b0, cfg.integral_zone}) && (err != '0);
    acc_sum  = {integ_base[ACC_W-1], integ_base}
             + {{(ACC_W+1-POS_W){err[POS_W-1]}}, err};
    acc_raw  = zone_hit ? acc_sum : '0;
    lim      = {2'b00, cfg.integral_limit};
    priority if (acc_raw > lim) begin
      acc_clamp = lim;
    end else if (acc_raw < -lim) begin
      acc_clamp = -lim;
    end else begin
      acc_clamp = acc_raw;
    end

    count_nxt  = (count_base != '1) ? count_base + CNT_W'(1) : count_base;
    thresh_hit = mag <= {1'b0, cfg.exit_threshold};
    timeout    = count_nxt >= cfg.timeout_samples;

    st_nxt.err       = err;
    st_nxt.acc       = acc_clamp[ACC_W-1:0];
    st_nxt.der       = {err[POS_W-1], err} - {prev_base[POS_W-1], prev_base};
    st_nxt.done      = thresh_hit || timeout;
    st_nxt.timed_out = !thresh_hit && timeout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      st_valid_r <= 1'b0;
      integ_r    <= '0;
      prev_r     <= '0;
      count_r    <= '0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
      st_valid_r <= s0_valid_r;
      if (s0_valid_r) begin
        integ_r <= acc_clamp[ACC_W-1:0];
        prev_r  <= err;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_first_r <= in_first;
      s0_sp_r    <= in_setpoint;
      s0_ms_r    <= in_measured;
      st_r       <= st_nxt;
    end
  end

  assign st_valid = st_valid_r;
  assign st       = st_r;

endmodule

// File: hdl/pidpc_mix.sv
module pidpc_mix import pidpc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    st_valid,
  input  pidpc_err_t              st,
  input  pidpc_cfg_t              cfg,
  output logic                    out_valid,
  output logic signed [DRV_W-1:0] out_drive,
  output logic signed [POS_W-1:0] out_err,
  output logic                    out_done,
  output logic                    out_timed_out
);

  // product stage
  logic                       pr_valid_r;
  logic signed [P_PROD_W-1:0] p_prod_r;
  logic signed [I_PROD_W-1:0] i_prod_r;
  logic signed [D_PROD_W-1:0] d_prod_r;
  logic signed [POS_W-1:0]    pr_err_r;
  logic                       pr_done_r;
  logic                       pr_to_r;

  // result register
  logic                       res_valid_r;
  logic signed [DRV_W-1:0]    drive_r;
  logic signed [POS_W-1:0]    err_r;
  logic                       done_r;
  logic                       to_r;

  logic signed [P_PROD_W-1:0] p_prod_nxt;
  logic signed [I_PROD_W-1:0] i_prod_nxt;
  logic signed [D_PROD_W-1:0] d_prod_nxt;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SHR_W-1:0]    shr;
  logic signed [SHR_W-1:0]    lim;
  logic signed [DRV_W-1:0]    drive_nxt;

  assign p_prod_nxt = $signed({1'b0, cfg.gain_p}) * $signed(st.err);
  assign i_prod_nxt = $signed({1'b0, cfg.gain_i}) * $signed(st.acc);
  assign d_prod_nxt = $signed({1'b0, cfg.gain_d}) * $signed(st.der);

  always_comb begin
    // add half an LSB of the output before the shift: ties go up
    sum = $signed({{(SUM_W-P_PROD_W){p_prod_r[P_PROD_W-1]}}, p_prod_r})
        + $signed({{(SUM_W-I_PROD_W){i_prod_r[I_PROD_W-1]}}, i_prod_r})
        + $signed({{(SUM_W-D_PROD_W){d_prod_r[D_PROD_W-1]}}, d_prod_r})
        + $signed(SUM_W'(1) <<< (FRAC_SH - 1));
    shr = sum[SUM_W-1:FRAC_SH];
    lim = $signed({{(SHR_W-15){1'b0}}, cfg.max_power});
    priority if (shr > lim) begin
      drive_nxt = lim[DRV_W-1:0];
    end else if (shr < -lim) begin
      drive_nxt = -lim[DRV_W-1:0];
    end else begin
      drive_nxt = shr[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (adv) begin
      pr_valid_r  <= st_valid;
      res_valid_r <= pr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_prod_r  <= p_prod_nxt;
      i_prod_r  <= i_prod_nxt;
      d_prod_r  <= d_prod_nxt;
      pr_err_r  <= st.err;
      pr_done_r <= st.done;
      pr_to_r   <= st.timed_out;
      drive_r   <= drive_nxt;
      err_r     <= pr_err_r;
      done_r    <= pr_done_r;
      to_r      <= pr_to_r;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_drive     = drive_r;
  assign out_err       = err_r;
  assign out_done      = done_r;
  assign out_timed_out = to_r;

endmodule

// File: hdl/pid_position_controller.sv
// Throughput: one sample per cycle while no result is stalled; the error, integral
// clamp and sample count form a feedback loop, the three gain products and their
// sum follow in two stages.
// A stalled result holds the whole pipeline and deasserts in_if.ready.
// Reset (synchronous, rst_n low): pipeline emptied, integral, previous error and
// sample count cleared, registers loaded with their default values.
module pid_position_controller import pidpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pidpc_in_if.sink          in_if,
  pidpc_out_if.source       out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  pidpc_cfg_t              cfg;
  pidpc_err_t              st;
  logic                    st_valid;
  logic                    adv;
  logic                    res_valid;
  logic signed [DRV_W-1:0] res_drive;
  logic signed [POS_W-1:0] res_err;
  logic                    res_done;
  logic                    res_to;
  logic [POS_W-1:0]        out_mag;

  // advance every stage unless a finished result is stalled
  assign adv         = !res_valid || out_if.ready;
  assign in_if.ready = adv;

  pidpc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  pidpc_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_if.valid),
    .in_first   (in_if.first),
    .in_setpoint(in_if.setpoint),
    .in_measured(in_if.measured),
    .cfg        (cfg),
    .st_valid   (st_valid),
    .st         (st)
  );

  pidpc_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .st_valid     (st_valid),
    .st           (st),
    .cfg          (cfg),
    .out_valid    (res_valid),
    .out_drive    (res_drive),
    .out_err      (res_err),
    .out_done     (res_done),
    .out_timed_out(res_to)
  );

  assign out_if.valid     = res_valid;
  assign out_if.drive     = res_drive;
  assign out_if.error_out = res_err;
  assign out_if.done_res  = res_done;
  assign out_if.timed_out = res_to;

  assign out_mag = res_err[POS_W-1] ? (~res_err + POS_W'(1)) : res_err;

  a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.drive <= $signed({1'b0, cfg.max_power}))
                  && (out_if.drive >= -$signed({1'b0, cfg.max_power})))
    else $error("drive outside max_power clamp");

  a_timeout_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.timed_out |-> out_if.done_res)
    else $error("timed_out without done_res");

  a_within_not_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_mag <= {1'b0, cfg.exit_threshold})
      |-> out_if.done_res && !out_if.timed_out)
    else $error("small error not flagged as done by threshold");

endmodule

// File: tb/tb_pid_position_controller.sv
module tb_pid_position_controller;
  import pidpc_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int WATCHDOG_CYCLES = 600_000;
  localparam int LONG_HOLD = 80;
  localparam int PHASE_SAMPLES = 225;
  localparam longint ERR_MAX = 64'sd8388607;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PATTERN, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic signed [POS_W-1:0] error_out;
    logic                    done_res;
    logic                    timed_out;
  } drive_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pidpc_in_if  sample_if();
  pidpc_out_if drive_if();

  pid_position_controller i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (sample_if),
    .out_if  (drive_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // controller state as the block should hold it
  pidpc_cfg_t              ctrl_regs;
  logic signed [ACC_W-1:0] integ_acc;
  logic signed [POS_W-1:0] prev_err;
  logic [CNT_W-1:0]        sample_cnt;
  drive_result_t           awaited_results[$];

  int          fail_count = 0;
  int          burst_left = 0;
  bit          bursty = 1'b1;
  bit          hold_off_req = 1'b0;
  stall_mode_e stall_mode = STALL_LIGHT;

  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin : watchdog
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("pid_position_controller verification failed");
    $finish;
  end

  function automatic void compute_drive(input logic f, input logic signed [POS_W-1:0] sp,
                                        input logic signed [POS_W-1:0] ms);
    longint err, mag, acc, der, sum, drv;
    longint gp, gi, gd, zone, lim, thr, pwr;
    drive_result_t r;
    gp   = ctrl_regs.gain_p;
    gi   = ctrl_regs.gain_i;
    gd   = ctrl_regs.gain_d;
    zone = ctrl_regs.integral_zone;
    lim  = ctrl_regs.integral_limit;
    thr  = ctrl_regs.exit_threshold;
    pwr  = ctrl_regs.max_power;
    if (f) begin
      integ_acc  = '0;
      prev_err   = '0;
      sample_cnt = '0;
    end
    // saturate symmetrically: the most negative code is never produced
    err = longint'(sp) - longint'(ms);
    if (err > ERR_MAX) err = ERR_MAX;
    else if (err < -ERR_MAX) err = -ERR_MAX;
    mag = (err < 0) ? -err : err;

    if (mag < zone && err != 0) acc = integ_acc + err;
    else acc = 0;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ_acc = acc[ACC_W-1:0];

    der = err - prev_err;
    prev_err = err[POS_W-1:0];

    sum = gp * err + gi * acc + gd * der;
    drv = (sum + 64'sd32768) >>> FRAC_SH;
    if (drv > pwr) drv = pwr;
    else if (drv < -pwr) drv = -pwr;

    if (sample_cnt != '1) sample_cnt++;

    r.drive     = drv[DRV_W-1:0];
    r.error_out = err[POS_W-1:0];
    r.done_res  = (mag <= thr) || (sample_cnt >= ctrl_regs.timeout_samples);
    r.timed_out = (mag > thr) && (sample_cnt >= ctrl_regs.timeout_samples);
    awaited_results.push_back(r);
  endfunction

  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && drive_if.valid && drive_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("drive transaction with no sample outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (drive_if.drive !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive, drive_if.drive);
          fail_count++;
        end
        if (drive_if.error_out !== want.error_out) begin
          $error("error_out: expected %0d, actual %0d", want.error_out, drive_if.error_out);
          fail_count++;
        end
        if (drive_if.done_res !== want.done_res) begin
          $error("done_res: expected %0b, actual %0b", want.done_res, drive_if.done_res);
          fail_count++;
        end
        if (drive_if.timed_out !== want.timed_out) begin
          $error("timed_out: expected %0b, actual %0b", want.timed_out, drive_if.timed_out);
          fail_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    logic [7:0] pattern;
    hold_left = 0;
    pattern = 8'b1011_0010;
    drive_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pattern = {pattern[6:0], pattern[7]};
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE:    drive_if.ready <= 1'b1;
          STALL_LIGHT:   drive_if.ready <= ($urandom_range(0, 3) != 0);
          STALL_PATTERN: drive_if.ready <= pattern[0];
          default:       drive_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_sample(input logic f, input logic signed [POS_W-1:0] sp,
                             input logic signed [POS_W-1:0] ms);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 20);
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    sample_if.valid    <= 1'b1;
    sample_if.first    <= f;
    sample_if.setpoint <= sp;
    sample_if.measured <= ms;
    do @(posedge clk); while (!sample_if.ready);
    compute_drive(f, sp, ms);
  endtask

  // drop valid and let the pipeline empty before touching the registers
  task automatic settle();
    sample_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_P:      ctrl_regs.gain_p          = value[23:0];
      REG_GAIN_I:      ctrl_regs.gain_i          = value[23:0];
      REG_GAIN_D:      ctrl_regs.gain_d          = value[23:0];
      REG_MAX_POWER:   ctrl_regs.max_power       = value[14:0];
      REG_INT_ZONE:    ctrl_regs.integral_zone   = value[22:0];
      REG_INT_LIMIT:   ctrl_regs.integral_limit  = value[30:0];
      REG_EXIT_THRESH: ctrl_regs.exit_threshold  = value[22:0];
      default:         ctrl_regs.timeout_samples = value[15:0];
    endcase
    @(posedge clk);
  endtask

  // fill the unused upper bits with noise when asked, they must be dropped
  function automatic logic [DATA_W-1:0] padded(input logic [DATA_W-1:0] v, input int w,
                                               input bit junk);
    return junk ? (v | ($urandom << w)) : v;
  endfunction

  task automatic program_regs(input pidpc_cfg_t s, input bit junk);
    write_reg(REG_GAIN_P,      padded(32'(s.gain_p), 24, junk));
    write_reg(REG_GAIN_I,      padded(32'(s.gain_i), 24, junk));
    write_reg(REG_GAIN_D,      padded(32'(s.gain_d), 24, junk));
    write_reg(REG_MAX_POWER,   padded(32'(s.max_power), 15, junk));
    write_reg(REG_INT_ZONE,    padded(32'(s.integral_zone), 23, junk));
    write_reg(REG_INT_LIMIT,   padded(32'(s.integral_limit), 31, junk));
    write_reg(REG_EXIT_THRESH, padded(32'(s.exit_threshold), 23, junk));
    write_reg(REG_TIMEOUT,     padded(32'(s.timeout_samples), 16, junk));
  endtask

  function automatic logic [31:0] spread_rand(input int w);
    return $urandom & ((32'd1 << $urandom_range(1, w)) - 32'd1);
  endfunction

  function automatic pidpc_cfg_t pick_settings(input int kind);
    pidpc_cfg_t s;
    s = CFG_RESET;
    case (kind)
      0: ;
      1: begin
        // every register at its top but the exit threshold, which is zero, power clamp above the nominal full scale
        s.gain_p          = '1;
        s.gain_i          = '1;
        s.gain_d          = '1;
        s.max_power       = '1;
        s.integral_zone   = '1;
        s.integral_limit  = '1;
        s.exit_threshold  = '0;
        s.timeout_samples = '1;
      end
      2: begin
        s.gain_p          = '0;
        s.gain_i          = '0;
        s.gain_d          = '0;
        s.max_power       = '0;
        s.integral_zone   = '0;
        s.integral_limit  = '0;
        s.exit_threshold  = '1;
        s.timeout_samples = '0;
      end
      3: s.timeout_samples = CNT_W'($urandom_range(1, 30));
      default: begin
        s.gain_p          = GAIN_W'(spread_rand(24));
        s.gain_i          = GAIN_W'(spread_rand(24));
        s.gain_d          = GAIN_W'(spread_rand(24));
        s.max_power       = 15'($urandom_range(0, 32767));
        s.integral_zone   = 23'(spread_rand(23));
        s.integral_limit  = 31'(spread_rand(31));
        s.exit_threshold  = 23'(spread_rand(12));
        s.timeout_samples = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 60))
                                                 : CNT_W'($urandom_range(0, 65535));
      end
    endcase
    return s;
  endfunction

  // a move that homes in on its setpoint, with wobble and the odd overshoot
  task automatic run_move(input int len, input bit fresh);
    logic signed [POS_W-1:0] sp;
    logic signed [POS_W-1:0] ms;
    longint err;
    longint m;
    sp = POS_W'($urandom);
    err = $urandom_range(0, (1 << $urandom_range(2, 23)) - 1);
    if ($urandom_range(0, 1)) err = -err;
    for (int k = 0; k < len; k++) begin
      m = longint'(sp) - err;
      if (m > POS_MAX) m = POS_MAX;
      else if (m < POS_MIN) m = POS_MIN;
      ms = m[POS_W-1:0];
      send_sample(fresh && k == 0, sp, ms);
      err = (err * int'($urandom_range(30, 110))) / 100 + int'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 9) == 0) err = -err / 2;
    end
  endtask

  task automatic test_error_extremes();
    send_sample(1'b1, POS_MAX, POS_MIN);
    send_sample(1'b0, POS_MIN, POS_MAX);
    send_sample(1'b0, POS_MIN, 24'sd0);
    send_sample(1'b0, 24'sd0, 24'sd0);
    send_sample(1'b0, 24'sd128, 24'sd0);
    send_sample(1'b0, -24'sd129, 24'sd0);
  endtask

  task automatic test_integral_zone();
    send_sample(1'b1, 24'sd3839, 24'sd0);
    send_sample(1'b0, 24'sd1000, 24'sd2000);
    send_sample(1'b0, 24'sd3840, 24'sd0);
    send_sample(1'b0, 24'sd0, -24'sd3839);
    send_sample(1'b0, 24'sd5, 24'sd5);
  endtask

  task automatic test_integral_limit();
    pidpc_cfg_t s;
    settle();
    s = CFG_RESET;
    s.integral_zone = '1;
    program_regs(s, 1'b0);
    send_sample(1'b1, POS_MAX, 24'sd1);
    send_sample(1'b0, -24'sd1, 24'sd2);
    // tighten the clamp under a loaded integral
    settle();
    write_reg(REG_INT_LIMIT, 32'd1000);
    send_sample(1'b0, 24'sd7, 24'sd0);
    send_sample(1'b0, -24'sd4000, 24'sd0);
  endtask

  task automatic test_sample_timeout();
    pidpc_cfg_t s;
    settle();
    s = CFG_RESET;
    s.timeout_samples = 16'd3;
    program_regs(s, 1'b0);
    send_sample(1'b1, 24'sd1000, 24'sd0);
    send_sample(1'b0, 24'sd1000, 24'sd0);
    send_sample(1'b0, 24'sd1000, 24'sd0);
    send_sample(1'b0, 24'sd10, 24'sd0);
    settle();
    write_reg(REG_TIMEOUT, 32'd0);
    send_sample(1'b1, 24'sd5000, 24'sd0);
    send_sample(1'b0, 24'sd0, 24'sd0);
  endtask

  task automatic test_backpressure();
    settle();
    program_regs(CFG_RESET, 1'b0);
    stall_mode = STALL_NONE;
    bursty = 1'b0;
    hold_off_req = 1'b1;
    run_move(120, 1'b1);
    settle();
  endtask

  task automatic test_random_moves();
    int sent;
    int len;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      program_regs(pick_settings(phase < 4 ? phase : 4), phase == 1 || $urandom_range(0, 1));
      stall_mode = stall_mode_e'(phase % 4);
      bursty = (phase % 3) != 0;
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        case ($urandom_range(0, 9))
          0: begin
            send_sample(1'($urandom_range(0, 1)), POS_W'($urandom), POS_W'($urandom));
            sent++;
          end
          1: begin
            // carry on without a move start
            len = $urandom_range(2, 20);
            run_move(len, 1'b0);
            sent += len;
          end
          default: begin
            len = $urandom_range(3, 40);
            run_move(len, 1'b1);
            sent += len;
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    sample_if.valid    <= 1'b0;
    sample_if.first    <= 1'b0;
    sample_if.setpoint <= '0;
    sample_if.measured <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    ctrl_regs  = CFG_RESET;
    integ_acc  = '0;
    prev_err   = '0;
    sample_cnt = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_error_extremes();
    test_integral_zone();
    test_integral_limit();
    test_sample_timeout();
    test_backpressure();
    test_random_moves();

    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_position_controller verification clean");
    end else begin
      $display("pid_position_controller verification failed");
    end
    $finish;
  end

endmodule
